// ----- rtl/vec3_normalize_unit_defines.svh -----
// Assertion macros shared by the checker of the vector normalisation block.
// No dependencies; the including module must provide clk and rst.
`ifndef VEC3_NORMALIZE_UNIT_DEFINES_SVH
`define VEC3_NORMALIZE_UNIT_DEFINES_SVH

// Implication checked at each clock edge, switched off while reset is high.
`define VNU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication that also holds across reset.
`define VNU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/vnu_pkg.sv -----
// Shared constants and pipeline payload types of the vector normalisation block.
// No dependencies.
package vnu_pkg;
  localparam int CB     = 16;             // component width
  localparam int FB     = 14;             // output fraction bits
  localparam int UB     = FB + 2;         // output component width
  localparam int SW     = 2 * CB;         // sum of squares width
  localparam int W      = 2 * CB + 2 * FB + 6;  // residual width, signed
  localparam int NITER  = FB + 1;         // one result bit per iteration stage
  localparam int BW     = $clog2(NITER);  // width of a bit index

  typedef struct packed {
    logic signed [W-1:0] d;   // remaining budget of the rounding condition
    logic signed [W-1:0] p;   // (2q - 1) * sum
    logic [FB:0]         q;   // result magnitude so far
    logic                neg; // sign of the input component
  } lane_t;

  typedef struct packed {
    lane_t [2:0]   lane;
    logic [SW-1:0] s;
    logic          zero;
  } item_t;
endpackage

// ----- rtl/vnu_front.sv -----
// Front end: magnitudes, squares and sum of squares over three register stages.
// Depends on vnu_pkg.
module vnu_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [vnu_pkg::CB-1:0]    in_x,
  input  logic [vnu_pkg::CB-1:0]    in_y,
  input  logic [vnu_pkg::CB-1:0]    in_z,
  output logic                      out_valid,
  output vnu_pkg::item_t            out_item
);
  import vnu_pkg::*;

  logic            a_v, b_v;
  logic [CB-1:0]   mag [3];
  logic [2:0]      neg_a, neg_b;
  logic [SW-1:0]   sq [3];
  logic [CB-1:0]   comp [3];
  logic [SW-1:0]   sum_next;

  assign comp[0] = in_x;
  assign comp[1] = in_y;
  assign comp[2] = in_z;
  assign sum_next = sq[0] + sq[1] + sq[2];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v       <= 1'b0;
      b_v       <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      a_v       <= in_valid;
      b_v       <= a_v;
      out_valid <= b_v;
    end
  end

  // The budget starts at 4 * mag^2 * 2^(2F) less the q = 0 term, (2*0 - 1)^2 * S.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        neg_a[i] <= comp[i][CB-1];
        mag[i]   <= comp[i][CB-1] ? (~comp[i] + CB'(1)) : comp[i];
        sq[i]    <= SW'(mag[i]) * SW'(mag[i]);
      end
      neg_b         <= neg_a;
      out_item.s    <= sum_next;
      out_item.zero <= (sum_next == '0);
      for (int i = 0; i < 3; i++) begin
        out_item.lane[i].d   <= (W'(sq[i]) << (2 * FB + 2)) - W'(sum_next);
        out_item.lane[i].p   <= -$signed(W'(sum_next));
        out_item.lane[i].q   <= '0;
        out_item.lane[i].neg <= neg_b[i];
      end
    end
  end
endmodule

// ----- rtl/vnu_iter.sv -----
// One digit-recurrence stage: decides one bit of each rounded unit component.
// Depends on vnu_pkg.
module vnu_iter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [vnu_pkg::BW-1:0] bit_idx,
  input  logic                  in_valid,
  input  vnu_pkg::item_t        in_item,
  output logic                  out_valid,
  output vnu_pkg::item_t        out_item
);
  import vnu_pkg::*;

  item_t item_next;

  // Trying bit b raises (2q-1)^2 * S by 2^(b+2) * P + 2^(2b+2) * S, and P by 2^(b+1) * S.
  always_comb begin
    logic signed [W-1:0] s_ext;
    logic signed [W-1:0] trial;
    s_ext     = $signed(W'(in_item.s));
    item_next = in_item;
    for (int i = 0; i < 3; i++) begin
      trial = (in_item.lane[i].p <<< (W'(bit_idx) + W'(2)))
            + (s_ext <<< ((W'(bit_idx) << 1) + W'(2)));
      if (!in_item.lane[i].q[FB] && (in_item.lane[i].d >= trial)) begin
        item_next.lane[i].d = in_item.lane[i].d - trial;
        item_next.lane[i].p = in_item.lane[i].p + (s_ext <<< (W'(bit_idx) + W'(1)));
        item_next.lane[i].q = in_item.lane[i].q | ((FB+1)'(1) << bit_idx);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= item_next;
    end
  end
endmodule

// ----- rtl/vec3_normalize_unit.sv -----
// Top level of the 3D vector normalisation block: front end, iteration chain, output.
// Depends on vnu_pkg, vnu_front and vnu_iter.
//
// Usage: one vector beat enters on the s_ channel (x, y, z as signed Q3.12) and one
// unit-vector beat leaves on the m_ channel (signed Q1.14), with tuser flagging a
// zero-length input, in which case all three components are zero.
// Each component is the correctly rounded value of c / sqrt(x*x + y*y + z*z), ties
// rounding away from zero.
// An accepted input beat passes through three front stages (magnitude, square, sum),
// fifteen recurrence stages each deciding one bit of the three magnitudes, and one
// output register that restores the signs. Throughput is one beat per cycle unless
// the receiver stalls; each recurrence stage holds one wide add and compare.
// The whole pipeline advances together whenever the output register is empty or is
// being taken, so s_tready follows m_tready; while the receiver stalls, every stage
// holds its beat and nothing is lost or repeated.
// Synchronous reset clears all valid bits; the data registers are not reset.
module vec3_normalize_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // in_x [15:0], in_y [31:16], in_z [47:32]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // unit_x [15:0], unit_y [31:16], unit_z [47:32]
  output logic        m_tuser    // zero_length [0]
);
  import vnu_pkg::*;

  logic  en;
  logic  v    [NITER+1];
  item_t stg  [NITER+1];
  logic [UB-1:0] unit [3];

  // Single advance enable for every stage: the output register is free or drained.
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  vnu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .in_x      (s_tdata[CB-1:0]),
    .in_y      (s_tdata[2*CB-1:CB]),
    .in_z      (s_tdata[3*CB-1:2*CB]),
    .out_valid (v[0]),
    .out_item  (stg[0])
  );

  // Stage k decides bit FB-k, most significant first.
  for (genvar k = 0; k < NITER; k++) begin : g_iter
    vnu_iter u_iter (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .bit_idx   (BW'(FB - k)),
      .in_valid  (v[k]),
      .in_item   (stg[k]),
      .out_valid (v[k+1]),
      .out_item  (stg[k+1])
    );
  end

  // Sign restore; a zero-length vector gives zeros.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (stg[NITER].zero) begin
        unit[i] = '0;
      end else if (stg[NITER].lane[i].neg) begin
        unit[i] = -UB'(stg[NITER].lane[i].q);
      end else begin
        unit[i] = UB'(stg[NITER].lane[i].q);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= v[NITER];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {unit[2], unit[1], unit[0]};
      m_tuser <= stg[NITER].zero;
    end
  end
endmodule

// ----- rtl/vnu_checker.sv -----
// Port-level checker for vec3_normalize_unit, attached by the bind at the end.
// Depends on vec3_normalize_unit_defines.svh.
`include "vec3_normalize_unit_defines.svh"

module vnu_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [47:0] m_tdata,
  input logic        m_tuser
);
  `VNU_ASSERT_NEXT(a_reset_empty, rst, !m_tvalid, "output valid after reset")
  `VNU_ASSERT_IMPL(a_stall_hold, $past(m_tvalid && !m_tready), m_tvalid && $stable(m_tdata) && $stable(m_tuser), "stalled beat changed")
  `VNU_ASSERT_IMPL(a_zero_data, m_tvalid && m_tuser, m_tdata == 48'd0, "zero-length beat with non-zero data")
  `VNU_ASSERT_IMPL(a_ready_follow, m_tready, s_tready, "input stalled while output drains")
endmodule

bind vec3_normalize_unit vnu_checker u_vnu_checker (.*);

// ----- dv/tb_vec3_normalize_unit.sv -----
// Testbench of the 3D vector normalisation block: random and directed vectors on the
// slave stream, unit vectors on the master stream checked against a built-in predictor.
// Depends on vec3_normalize_unit (and its package vnu_pkg).
`timescale 1ns / 1ps

module tb_vec3_normalize_unit;

  typedef struct {
    logic [15:0] ux, uy, uz;
    logic        zl;
  } unit_vec_t;

  // Rounded magnitude |c| * 2^14 / sqrt(sum): largest q in 0..2^14 with
  // (2q-1)^2 * sum <= 4 * mag^2 * 2^28, built one bit at a time.
  function automatic logic [14:0] round_unit_mag(logic [16:0] mag, logic [33:0] sum);
    logic [14:0] q;
    logic [14:0] t;
    logic [127:0] lhs, rhs;
    q = '0;
    rhs = (128'(mag) * 128'(mag)) << 30;
    for (int b = 14; b >= 0; b--) begin
      t = q | (15'd1 << b);
      if (t <= 15'd16384) begin
        lhs = (128'(2 * t - 1) * 128'(2 * t - 1)) * 128'(sum);
        if (lhs <= rhs) q = t;
      end
    end
    return q;
  endfunction

  function automatic unit_vec_t normalise(logic [47:0] v);
    logic [16:0] mag [3];
    logic        neg [3];
    logic [33:0] sum;
    logic [15:0] comp [3];
    logic [14:0] q;
    unit_vec_t   r;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[16*i+15];
      mag[i] = neg[i] ? (17'h10000 - {1'b0, v[16*i +: 16]}) : {1'b0, v[16*i +: 16]};
      sum += 34'(mag[i]) * 34'(mag[i]);
    end
    for (int i = 0; i < 3; i++) begin
      q = (sum == 0) ? 15'd0 : round_unit_mag(mag[i], sum);
      comp[i] = neg[i] ? (16'd0 - {1'b0, q}) : {1'b0, q};
    end
    r.ux = comp[0];
    r.uy = comp[1];
    r.uz = comp[2];
    r.zl = (sum == 0);
    return r;
  endfunction

  class unit_vec_scoreboard;
    unit_vec_t pending[$];
    int        errors = 0;

    function void note_vector(logic [47:0] v);
      pending.push_back(normalise(v));
    endfunction

    function void check_unit(logic [47:0] d, logic zl);
      unit_vec_t e;
      if (pending.size() == 0) begin
        $error("unexpected output beat: data %h zero_length %b", d, zl);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[15:0] !== e.ux) begin
        $error("unit_x: expected %h, actual %h", e.ux, d[15:0]); errors++;
      end
      if (d[31:16] !== e.uy) begin
        $error("unit_y: expected %h, actual %h", e.uy, d[31:16]); errors++;
      end
      if (d[47:32] !== e.uz) begin
        $error("unit_z: expected %h, actual %h", e.uz, d[47:32]); errors++;
      end
      if (zl !== e.zl) begin
        $error("zero_length: expected %b, actual %b", e.zl, zl); errors++;
      end
    endfunction
  endclass

  localparam int WATCHDOG_LIMIT = 5000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;
  logic        m_tuser;

  unit_vec_scoreboard sb = new();
  logic [47:0] vectors[$];
  int  idle_cycles = 0;
  bit  sending_done = 0;

  always #5 clk = ~clk;

  vec3_normalize_unit DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  // Sampling at the rising edge: inputs accepted are predicted, outputs checked.
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_vector(s_tdata);
      if (m_tvalid && m_tready) sb.check_unit(m_tdata, m_tuser);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  // The receiver stalls in a pattern of its own: stretches of full readiness,
  // stretches of random stalls, and the odd long hold.
  initial begin
    int mode;
    int len;
    @(negedge clk);
    while (1) begin
      mode = $urandom_range(0, 3);
      len  = $urandom_range(1, 40);
      repeat (len) begin
        case (mode)
          0: m_tready <= 1'b1;
          1: m_tready <= ($urandom_range(0, 3) != 0);
          2: m_tready <= $urandom_range(0, 1);
          default: m_tready <= (len > 30) ? 1'b0 : $urandom_range(0, 1);
        endcase
        @(negedge clk);
      end
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(0, 7))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'(($urandom_range(0, 1) ? -1 : 1) * $urandom_range(0, 8));
      default: return 16'($urandom);
    endcase
  endfunction

  // Sends one vector beat, holding tvalid until it is taken.
  task automatic send_vector(logic [47:0] v);
    s_tvalid <= 1'b1;
    s_tdata  <= v;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int burst;
    // Directed corner cases: zero vector, extremes, small values and axes.
    vectors.push_back(48'h0);
    vectors.push_back({16'h0000, 16'h0000, 16'h8000});
    vectors.push_back({16'h0000, 16'h8000, 16'h0000});
    vectors.push_back({16'h8000, 16'h0000, 16'h0000});
    vectors.push_back({16'h7FFF, 16'h7FFF, 16'h7FFF});
    vectors.push_back({16'h8000, 16'h8000, 16'h8000});
    vectors.push_back({16'h7FFF, 16'h8000, 16'h7FFF});
    vectors.push_back({16'h0000, 16'h0000, 16'h0001});
    vectors.push_back({16'h0000, 16'h0000, 16'hFFFF});
    vectors.push_back({16'h0001, 16'h0001, 16'h0001});
    vectors.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
    vectors.push_back({16'h0000, 16'h0004, 16'h0003});
    vectors.push_back({16'h0000, 16'hFFFC, 16'hFFFD});
    vectors.push_back({16'h0002, 16'h0001, 16'h0002});
    vectors.push_back({16'h0000, 16'h0001, 16'h0001});
    vectors.push_back({16'h1000, 16'h0000, 16'h7FFF});
    vectors.push_back({16'h5555, 16'hAAAA, 16'h0000});
    vectors.push_back({16'h0000, 16'h0000, 16'h0000});
    for (int i = 0; i < 1000; i++)
      vectors.push_back({rand_comp(), rand_comp(), rand_comp()});

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Bursts of random length separated by random gaps, sometimes none.
    while (vectors.size() > 0) begin
      burst = $urandom_range(1, 30);
      while (burst > 0 && vectors.size() > 0) begin
        send_vector(vectors.pop_front());
        burst--;
      end
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    s_tvalid <= 1'b0;
    sending_done = 1;
  end

  // End of run: wait for every expected beat, then allow the pipeline to settle.
  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  // Watchdog: too long without any beat moving ends the run.
  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

endmodule
